/* rtl/encoder_angle_sector_tracker_defines.svh */
// Assertion macros shared by the tracker RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ENCODER_ANGLE_SECTOR_TRACKER_DEFINES_SVH
`define ENCODER_ANGLE_SECTOR_TRACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define EAST_CHECK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define EAST_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define EAST_CHECK_IMPL(lbl, ante, cons, msg)
`define EAST_CHECK_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/east_pkg.sv */
`timescale 1ns / 1ps

package east_pkg;

  // field widths
  localparam int CNT_W = 16;
  localparam int TOT_W = 32;
  localparam int ANG_W = 16;
  localparam int IDX_W = 6;
  localparam int QRY_W = 8;
  localparam int TOL_W = 16;

  localparam int IN_DATA_W  = 32;  // 25 bits used
  localparam int OUT_DATA_W = 56;  // 55 bits used

  localparam int REV_COUNTS = 4000;
  localparam int RAIL_COUNT = 6;

  localparam int FULL_CDEG   = 36000;
  localparam int HALF_CDEG   = FULL_CDEG / 2;
  localparam int SECTOR_CDEG = FULL_CDEG / RAIL_COUNT;

  // residue of the total modulo one revolution
  localparam int RES_W = $clog2(REV_COUNTS);
  localparam int SUM_W = RES_W + 2;

  // 2^32 mod CPR: residue shift when the 32-bit total wraps
  localparam longint TWO_POW_TOT = longint'(1) << TOT_W;
  localparam longint WRAP_RES    = TWO_POW_TOT % REV_COUNTS;
  localparam longint ADJ_POS     = (REV_COUNTS - WRAP_RES) % REV_COUNTS;
  localparam longint ADJ_NEG     = WRAP_RES;

  // delta mod CPR: offset delta to non-negative, reciprocal multiply
  localparam int X_W       = 18;
  localparam int DLT_OFF   = ((32768 + REV_COUNTS - 1) / REV_COUNTS) * REV_COUNTS;
  localparam int DM_RECIP  = (1 << X_W) / REV_COUNTS;

  // angle = floor(res * FULL / CPR) via ceil reciprocal, 32 fraction bits
  localparam int ANG_FRAC = 32;
  localparam int ANG_K_W  = 48;
  localparam logic [ANG_K_W-1:0] ANG_K =
    ANG_K_W'(((longint'(FULL_CDEG) << ANG_FRAC) + REV_COUNTS - 1) / REV_COUNTS);

  // per-item sideband carried along the front of the pipe
  typedef struct packed {
    logic signed [CNT_W-1:0] delta;
    logic                    zero;
    logic                    qvalid;
    logic [ANG_W-1:0]        target;
  } side_t;

endpackage

/* rtl/east_delta_mod.sv */
`timescale 1ns / 1ps

// Two-stage reduction of a signed 16-bit delta modulo REV_COUNTS.
module east_delta_mod import east_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  side_t            in_side,
  output logic             out_valid,
  output logic [RES_W-1:0] out_dm,
  output side_t            out_side
);

  logic             b_v_r;
  logic [X_W-1:0]   b_x_r;
  logic [X_W-1:0]   b_q_r;
  side_t            b_side_r;

  logic [X_W-1:0]   x_nxt;
  logic [2*X_W-1:0] q_prod;
  logic [X_W-1:0]   qc;
  logic [X_W-1:0]   r_raw;
  logic [X_W-1:0]   r_fix;

  // offset by a multiple of CPR so the dividend is non-negative
  assign x_nxt  = {{(X_W-CNT_W){in_side.delta[CNT_W-1]}}, in_side.delta} + X_W'(DLT_OFF);
  assign q_prod = x_nxt * X_W'(DM_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_x_r    <= x_nxt;
      b_q_r    <= q_prod[X_W +: X_W];
      b_side_r <= in_side;
    end
  end

  // quotient estimate is exact or one low
  assign qc    = X_W'(b_q_r * X_W'(REV_COUNTS));
  assign r_raw = b_x_r - qc;
  assign r_fix = (r_raw >= X_W'(REV_COUNTS)) ? r_raw - X_W'(REV_COUNTS) : r_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dm   <= RES_W'(r_fix);
      out_side <= b_side_r;
    end
  end

endmodule

/* rtl/encoder_angle_sector_tracker.sv */
`timescale 1ns / 1ps
// A result passes stages A to F and the output register before it shows on out_tvalid.
// Throughput: one request per cycle; the output register plus a one-entry skid
// stage keep in_tready high until two results wait; then the whole pipe holds.
// Reset (rst_n low, synchronous): clears pipe valids, counter reference, total,
// residue and tolerance; no memories, so no clearing pass.
`include "encoder_angle_sector_tracker_defines.svh"

module encoder_angle_sector_tracker import east_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: [15:0] raw_count, [16] zero_request, [24:17] rail_query, rest zero
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: [31:0] total_counts, [47:32] angle, [53:48] rail_index,
  //            [54] rail_aligned, [55] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // tolerance register write
  input  logic                  cfg_we,
  input  logic [TOL_W-1:0]      cfg_wdata
);

  typedef struct packed {
    logic             aligned;
    logic [IDX_W-1:0] idx;
    logic [ANG_W-1:0] angle;
    logic [TOT_W-1:0] total;
  } result_t;

  // pipe advances whenever the skid entry is free
  logic pipe_en;
  logic accept;
  logic skid_v_r;

  logic [TOL_W-1:0] tol_r;

  // input fields
  logic [CNT_W-1:0] in_raw;
  logic             in_zero;
  logic [QRY_W-1:0] in_query;

  assign in_raw   = in_tdata[CNT_W-1:0];
  assign in_zero  = in_tdata[CNT_W];
  assign in_query = in_tdata[CNT_W+1 +: QRY_W];

  // ---------------------------------------------------------------------------
  // Stage A: counter difference against the stored reference, rail target
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] last_raw_r;
  logic             a_v_r;
  side_t            a_side_r;
  side_t            a_side_nxt;

  assign pipe_en   = !skid_v_r;
  assign in_tready = pipe_en;
  assign accept    = in_tvalid && pipe_en;

  always_comb begin
    a_side_nxt.delta  = CNT_W'(in_raw - last_raw_r);  // wraps mod 2^16
    a_side_nxt.zero   = in_zero;
    a_side_nxt.qvalid = in_query < QRY_W'(RAIL_COUNT);
    a_side_nxt.target = ANG_W'(int'(in_query) * SECTOR_CDEG);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= '0;
      a_v_r      <= 1'b0;
    end else if (pipe_en) begin
      a_v_r <= accept;
      if (accept) begin
        last_raw_r <= in_raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a_side_r <= a_side_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages B, C: delta modulo one revolution
  // ---------------------------------------------------------------------------
  logic             c_v;
  logic [RES_W-1:0] c_dm;
  side_t            c_side;

  east_delta_mod u_delta_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (a_v_r),
    .in_side   (a_side_r),
    .out_valid (c_v),
    .out_dm    (c_dm),
    .out_side  (c_side)
  );

  // ---------------------------------------------------------------------------
  // Stage D: running total and its residue mod CPR, updated together.
  // The residue tracks the signed total; a 32-bit wrap shifts it by 2^32 mod CPR.
  // ---------------------------------------------------------------------------
  logic [TOT_W-1:0] total_r;
  logic [RES_W-1:0] res_r;
  logic             d_v_r;
  logic             d_qvalid_r;
  logic [ANG_W-1:0] d_target_r;

  logic [TOT_W-1:0] dext;
  logic [TOT_W-1:0] tsum;
  logic             pos_ovf;
  logic             neg_ovf;
  logic [SUM_W-1:0] rsum;
  logic [SUM_W-1:0] rred;

  assign dext    = {{(TOT_W-CNT_W){c_side.delta[CNT_W-1]}}, c_side.delta};
  assign tsum    = total_r + dext;
  assign pos_ovf = !total_r[TOT_W-1] && !dext[TOT_W-1] &&  tsum[TOT_W-1];
  assign neg_ovf =  total_r[TOT_W-1] &&  dext[TOT_W-1] && !tsum[TOT_W-1];

  always_comb begin
    rsum = SUM_W'(res_r) + SUM_W'(c_dm);
    if (pos_ovf) begin
      rsum = rsum + SUM_W'(ADJ_POS);
    end else if (neg_ovf) begin
      rsum = rsum + SUM_W'(ADJ_NEG);
    end
    // rsum < 3*CPR
    if (rsum >= SUM_W'(2 * REV_COUNTS)) begin
      rred = rsum - SUM_W'(2 * REV_COUNTS);
    end else if (rsum >= SUM_W'(REV_COUNTS)) begin
      rred = rsum - SUM_W'(REV_COUNTS);
    end else begin
      rred = rsum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      res_r   <= '0;
      d_v_r   <= 1'b0;
    end else if (pipe_en) begin
      d_v_r <= c_v;
      if (c_v) begin
        if (c_side.zero) begin
          total_r <= '0;
          res_r   <= '0;
        end else begin
          total_r <= tsum;
          res_r   <= RES_W'(rred);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      d_qvalid_r <= c_side.qvalid;
      d_target_r <= c_side.target;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: residue to centidegrees, one constant-reciprocal multiply.
  // total_r/res_r hold the item sitting in stage D.
  // ---------------------------------------------------------------------------
  logic                     e_v_r;
  logic [TOT_W-1:0]         e_total_r;
  logic [ANG_W-1:0]         e_angle_r;
  logic                     e_qvalid_r;
  logic [ANG_W-1:0]         e_target_r;
  logic [RES_W+ANG_K_W-1:0] ang_prod;

  assign ang_prod = (RES_W+ANG_K_W)'(res_r) * (RES_W+ANG_K_W)'(ANG_K);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (pipe_en) begin
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      e_total_r  <= total_r;
      e_angle_r  <= ang_prod[ANG_FRAC +: ANG_W];
      e_qvalid_r <= d_qvalid_r;
      e_target_r <= d_target_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F: sector by parallel compares against the sector edges,
  // plain distance to the queried rail
  // ---------------------------------------------------------------------------
  logic             f_v_r;
  logic [TOT_W-1:0] f_total_r;
  logic [ANG_W-1:0] f_angle_r;
  logic [IDX_W-1:0] f_idx_r;
  logic [ANG_W-1:0] f_diff_r;
  logic             f_qvalid_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [ANG_W-1:0] diff_nxt;

  always_comb begin
    idx_nxt = '0;
    for (int k = 1; k <= RAIL_COUNT; k++) begin
      if (e_angle_r >= ANG_W'(k * SECTOR_CDEG)) begin
        idx_nxt = idx_nxt + IDX_W'(1);
      end
    end
  end

  assign diff_nxt = (e_angle_r >= e_target_r) ? e_angle_r - e_target_r
                                              : e_target_r - e_angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (pipe_en) begin
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      f_total_r  <= e_total_r;
      f_angle_r  <= e_angle_r;
      f_idx_r    <= idx_nxt;
      f_diff_r   <= diff_nxt;
      f_qvalid_r <= e_qvalid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output: circular fold, tolerance check, output register + skid entry
  // ---------------------------------------------------------------------------
  logic [ANG_W-1:0] fold;
  result_t          new_res;
  result_t          out_q;
  result_t          skid_q;
  logic             out_v_r;

  assign fold = (f_diff_r > ANG_W'(HALF_CDEG)) ? ANG_W'(FULL_CDEG) - f_diff_r : f_diff_r;

  always_comb begin
    new_res.total   = f_total_r;
    new_res.angle   = f_angle_r;
    new_res.idx     = f_idx_r;
    new_res.aligned = f_qvalid_r && (fold <= tol_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_tready) begin
      out_v_r <= f_v_r;
    end else if (f_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_q <= skid_q;
      end
    end else if (!out_v_r || out_tready) begin
      out_q <= new_res;
    end else begin
      skid_q <= new_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_q};

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `EAST_CHECK_IMPL(a_skid_needs_out, skid_v_r, out_v_r, "skid entry held with no pending output")
  `EAST_CHECK_IMPL(a_res_range, 1'b1, (RES_W+1)'(res_r) < (RES_W+1)'(REV_COUNTS), "bad residue")
  `EAST_CHECK_NEXT(a_zero_clears, pipe_en && c_v && c_side.zero, ~|total_r && ~|res_r, "no clear")
  `EAST_CHECK_IMPL(a_angle_range, out_v_r, out_q.angle < ANG_W'(FULL_CDEG), "angle too big")
  `EAST_CHECK_IMPL(a_idx_range, out_v_r, out_q.idx <= IDX_W'(RAIL_COUNT), "sector too big")

endmodule
